// ===== hdl/quaternion_pose_vertex_transform_assert.svh =====
// Assertion macros shared by the vertex transform RTL.
`ifndef QUATERNION_POSE_VERTEX_TRANSFORM_ASSERT_SVH
`define QUATERNION_POSE_VERTEX_TRANSFORM_ASSERT_SVH
`ifndef SYNTHESIS
`define QPVT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("qpvt assertion failed");
`define QPVT_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("qpvt reset assertion failed");
`else
`define QPVT_ASSERT(lbl, prop)
`define QPVT_ASSERT_RST(lbl, prop)
`endif
`endif

// ===== hdl/qpvt_pkg.sv =====
package qpvt_pkg;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned QUAT_W  = 16;
  localparam int unsigned VEC_W   = 3 * COORD_W;
  localparam int unsigned ADDR_W  = 6;
  localparam int unsigned DATA_W  = 64;

  // Register indexes, taken from paddr[5:3].
  localparam logic [2:0] REG_QUAT_W  = 3'd0;
  localparam logic [2:0] REG_QUAT_X  = 3'd1;
  localparam logic [2:0] REG_QUAT_Y  = 3'd2;
  localparam logic [2:0] REG_QUAT_Z  = 3'd3;
  localparam logic [2:0] REG_SHIFT_X = 3'd4;
  localparam logic [2:0] REG_SHIFT_Y = 3'd5;
  localparam logic [2:0] REG_SHIFT_Z = 3'd6;
  localparam logic [2:0] REG_SCALES  = 3'd7;

  localparam logic [15:0] QUAT_W_RESET = 16'sd32767;
  localparam logic [47:0] SCALES_RESET = 48'h1000_1000_1000;

  // Divider runs one quotient bit per cycle over the whole 64-bit dividend.
  localparam logic [6:0] DIV_STEPS = 7'd64;
  localparam logic [3:0] LAST_ENTRY = 4'd8;

  typedef enum logic [3:0] {
    ST_PROD = 4'b0001,
    ST_NUM  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_IDLE = 4'b1000
  } seq_state_t;

endpackage

// ===== hdl/quaternion_pose_vertex_transform.sv =====
// Throughput: one vertex per cycle; the five-stage multiply/accumulate pipeline
// advances whenever the output register is empty or being taken.
// Reset and every quaternion write start a rotation matrix rebuild (one shared
// divider, used for each of the nine entries in turn) during which in_tready is low.
// Reset is synchronous, active low; configuration registers return to identity pose values.
`include "quaternion_pose_vertex_transform_assert.svh"
module quaternion_pose_vertex_transform (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [qpvt_pkg::VEC_W-1:0]   in_tdata,   // vertex_x, vertex_y, vertex_z
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [qpvt_pkg::VEC_W-1:0]   out_tdata,  // moved_x, moved_y, moved_z
  output logic                         out_tuser,  // clipped
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [qpvt_pkg::ADDR_W-1:0]  paddr,
  input  logic [qpvt_pkg::DATA_W-1:0]  pwdata,
  output logic [qpvt_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);
  import qpvt_pkg::*;

  // Configuration registers.
  logic signed [QUAT_W-1:0]  quat_r [4];
  logic signed [COORD_W-1:0] shift_r [3];
  logic [47:0]               scales_r;
  logic                      wr_en;
  logic [2:0]                reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quat_r[0]  <= QUAT_W_RESET;
      quat_r[1]  <= '0;
      quat_r[2]  <= '0;
      quat_r[3]  <= '0;
      shift_r[0] <= '0;
      shift_r[1] <= '0;
      shift_r[2] <= '0;
      scales_r   <= SCALES_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_QUAT_W:  quat_r[0]  <= pwdata[15:0];
        REG_QUAT_X:  quat_r[1]  <= pwdata[15:0];
        REG_QUAT_Y:  quat_r[2]  <= pwdata[15:0];
        REG_QUAT_Z:  quat_r[3]  <= pwdata[15:0];
        REG_SHIFT_X: shift_r[0] <= pwdata[31:0];
        REG_SHIFT_Y: shift_r[1] <= pwdata[31:0];
        REG_SHIFT_Z: shift_r[2] <= pwdata[31:0];
        REG_SCALES:  scales_r   <= pwdata[47:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_QUAT_W:  prdata = {{48{quat_r[0][15]}}, quat_r[0]};
      REG_QUAT_X:  prdata = {{48{quat_r[1][15]}}, quat_r[1]};
      REG_QUAT_Y:  prdata = {{48{quat_r[2][15]}}, quat_r[2]};
      REG_QUAT_Z:  prdata = {{48{quat_r[3][15]}}, quat_r[3]};
      REG_SHIFT_X: prdata = {{32{shift_r[0][31]}}, shift_r[0]};
      REG_SHIFT_Y: prdata = {{32{shift_r[1][31]}}, shift_r[1]};
      REG_SHIFT_Z: prdata = {{32{shift_r[2][31]}}, shift_r[2]};
      REG_SCALES:  prdata = {16'd0, scales_r};
      default:     prdata = '0;
    endcase
  end

  // Rotation matrix builder: products, numerators, then one shared divider.
  seq_state_t                state_r;
  logic signed [31:0]        sq_r [4];
  logic signed [31:0]        cr_r [6];   // xy, zw, xz, yw, yz, xw
  logic [32:0]               n_r;
  logic signed [34:0]        num_r [9];
  logic                      zero_r;
  logic [3:0]                kidx_r;
  logic [6:0]                bcnt_r;
  logic [63:0]               dvd_r;
  logic [32:0]               rem_r;
  logic [30:0]               quo_r;
  logic signed [31:0]        rmat_r [9];
  logic                      quat_wr;
  logic signed [34:0]        num_sel;
  logic [33:0]               num_mag;
  logic [33:0]               trial;
  logic                      ge;
  logic [31:0]               quo_fin;
  logic signed [34:0]        e_ww, e_xx, e_yy, e_zz;
  logic signed [34:0]        e_cr [6];

  assign quat_wr = wr_en && (reg_idx == REG_QUAT_W || reg_idx == REG_QUAT_X ||
                             reg_idx == REG_QUAT_Y || reg_idx == REG_QUAT_Z);
  assign num_sel = num_r[kidx_r];
  assign num_mag = num_sel[34] ? 34'(-num_sel) : num_sel[33:0];
  assign trial   = {rem_r, dvd_r[63]};
  assign ge      = trial >= {1'b0, n_r};
  assign quo_fin = {quo_r, ge};

  assign e_ww = 35'(sq_r[0]);
  assign e_xx = 35'(sq_r[1]);
  assign e_yy = 35'(sq_r[2]);
  assign e_zz = 35'(sq_r[3]);
  always_comb begin
    for (int i = 0; i < 6; i++) begin
      e_cr[i] = 35'(cr_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_PROD;
      kidx_r  <= '0;
      bcnt_r  <= '0;
    end else if (quat_wr) begin
      state_r <= ST_PROD;
    end else begin
      unique case (state_r)
        ST_PROD: begin
          sq_r[0] <= quat_r[0] * quat_r[0];
          sq_r[1] <= quat_r[1] * quat_r[1];
          sq_r[2] <= quat_r[2] * quat_r[2];
          sq_r[3] <= quat_r[3] * quat_r[3];
          cr_r[0] <= quat_r[1] * quat_r[2];
          cr_r[1] <= quat_r[3] * quat_r[0];
          cr_r[2] <= quat_r[1] * quat_r[3];
          cr_r[3] <= quat_r[2] * quat_r[0];
          cr_r[4] <= quat_r[2] * quat_r[3];
          cr_r[5] <= quat_r[1] * quat_r[0];
          state_r <= ST_NUM;
        end
        ST_NUM: begin
          n_r      <= 33'(sq_r[0]) + 33'(sq_r[1]) + 33'(sq_r[2]) + 33'(sq_r[3]);
          zero_r   <= (sq_r[0] | sq_r[1] | sq_r[2] | sq_r[3]) == '0;
          num_r[0] <= e_ww + e_xx - e_yy - e_zz;
          num_r[1] <= (e_cr[0] - e_cr[1]) <<< 1;
          num_r[2] <= (e_cr[2] + e_cr[3]) <<< 1;
          num_r[3] <= (e_cr[0] + e_cr[1]) <<< 1;
          num_r[4] <= e_ww - e_xx + e_yy - e_zz;
          num_r[5] <= (e_cr[4] - e_cr[5]) <<< 1;
          num_r[6] <= (e_cr[2] - e_cr[3]) <<< 1;
          num_r[7] <= (e_cr[4] + e_cr[5]) <<< 1;
          num_r[8] <= e_ww - e_xx - e_yy + e_zz;
          kidx_r   <= '0;
          bcnt_r   <= '0;
          state_r  <= ((sq_r[0] | sq_r[1] | sq_r[2] | sq_r[3]) == '0) ? ST_IDLE : ST_DIV;
        end
        ST_DIV: begin
          if (bcnt_r == '0) begin
            // Rounding to nearest is folded in by adding half the divisor.
            dvd_r  <= {num_mag, 30'd0} + {31'd0, n_r[32:1]};
            rem_r  <= '0;
            quo_r  <= '0;
            bcnt_r <= 7'd1;
          end else begin
            rem_r <= ge ? 33'(trial - {1'b0, n_r}) : trial[32:0];
            dvd_r <= {dvd_r[62:0], 1'b0};
            quo_r <= quo_fin[30:0];
            if (bcnt_r == DIV_STEPS) begin
              rmat_r[kidx_r] <= num_sel[34] ? -quo_fin : quo_fin;
              bcnt_r         <= '0;
              if (kidx_r == LAST_ENTRY) begin
                state_r <= ST_IDLE;
              end else begin
                kidx_r <= kidx_r + 4'd1;
              end
            end else begin
              bcnt_r <= bcnt_r + 7'd1;
            end
          end
        end
        ST_IDLE: ;
        default: state_r <= ST_PROD;
      endcase
    end
  end

  // Vertex pipeline.
  logic                      adv;
  logic                      v1_r, v2_r, v3_r, v4_r, out_tvalid_r;
  logic [VEC_W-1:0]          raw1_r, raw2_r, raw3_r, raw4_r;
  logic signed [47:0]        prod1_r [3];
  logic signed [35:0]        sc2_r [3];
  logic signed [52:0]        ph3_r [3][3];
  logic signed [51:0]        pl3_r [3][3];
  logic signed [54:0]        ah4_r [3];
  logic signed [53:0]        al4_r [3];
  logic [VEC_W-1:0]          out_data_r;
  logic                      clip_r;
  logic signed [47:0]        rnd1 [3];
  logic signed [16:0]        rh [9];
  logic signed [15:0]        rl [9];
  logic signed [55:0]        b5 [3];
  logic signed [40:0]        r5 [3];
  logic signed [41:0]        v5 [3];
  logic [COORD_W-1:0]        sat5 [3];
  logic [2:0]                ovf5;

  assign adv        = !out_tvalid_r || out_tready;
  assign in_tready  = adv && (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = clip_r;

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      rh[k] = rmat_r[k][31:15];
      rl[k] = {1'b0, rmat_r[k][14:0]};
    end
    for (int i = 0; i < 3; i++) begin
      rnd1[i] = prod1_r[i] + 48'sd2048;
    end
    for (int c = 0; c < 3; c++) begin
      b5[c]   = 56'(ah4_r[c]) + 56'(al4_r[c] >>> 15);
      r5[c]   = 41'((b5[c] + 56'sd16384) >>> 15);
      v5[c]   = 42'(r5[c]) + 42'(shift_r[c]);
      ovf5[c] = !((&v5[c][41:31]) || !(|v5[c][41:31]));
      if (ovf5[c]) begin
        sat5[c] = v5[c][41] ? 32'h8000_0000 : 32'h7fff_ffff;
      end else begin
        sat5[c] = v5[c][31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      v3_r         <= 1'b0;
      v4_r         <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else if (adv) begin
      v1_r         <= in_tvalid && in_tready;
      v2_r         <= v1_r;
      v3_r         <= v2_r;
      v4_r         <= v3_r;
      out_tvalid_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      raw1_r <= in_tdata;
      raw2_r <= raw1_r;
      raw3_r <= raw2_r;
      raw4_r <= raw3_r;
      for (int i = 0; i < 3; i++) begin
        prod1_r[i] <= $signed(scales_r[16*i +: 16]) * $signed(in_tdata[32*i +: 32]);
        sc2_r[i]   <= rnd1[i][47:12];
        for (int c = 0; c < 3; c++) begin
          ph3_r[i][c] <= sc2_r[i] * rh[3*i + c];
          pl3_r[i][c] <= sc2_r[i] * rl[3*i + c];
        end
      end
      for (int c = 0; c < 3; c++) begin
        ah4_r[c] <= 55'(ph3_r[0][c]) + 55'(ph3_r[1][c]) + 55'(ph3_r[2][c]);
        al4_r[c] <= 54'(pl3_r[0][c]) + 54'(pl3_r[1][c]) + 54'(pl3_r[2][c]);
      end
      // A zero quaternion passes the vertex through untouched.
      if (zero_r) begin
        out_data_r <= raw4_r;
        clip_r     <= 1'b0;
      end else begin
        out_data_r <= {sat5[2], sat5[1], sat5[0]};
        clip_r     <= |ovf5;
      end
    end
  end

  `QPVT_ASSERT(a_no_accept_busy, (in_tvalid && in_tready) |-> (state_r == ST_IDLE))
  `QPVT_ASSERT(a_bypass_no_clip, (out_tvalid && out_tuser) |-> !zero_r)
  `QPVT_ASSERT(a_div_range, (state_r == ST_DIV) |-> (bcnt_r <= DIV_STEPS && kidx_r <= LAST_ENTRY))
  `QPVT_ASSERT_RST(a_reset_rebuild, !rst_n |=> (state_r == ST_PROD) && !out_tvalid_r)

endmodule
